[hdl/hrhp_pkg.sv]
package hrhp_pkg;

    localparam int unsigned STATE_W = 5;

    // Parser states
    localparam logic [STATE_W-1:0] ST_METHOD_START = 5'd0;
    localparam logic [STATE_W-1:0] ST_METHOD       = 5'd1;
    localparam logic [STATE_W-1:0] ST_URI          = 5'd2;
    localparam logic [STATE_W-1:0] ST_VER_H        = 5'd3;
    localparam logic [STATE_W-1:0] ST_VER_T1       = 5'd4;
    localparam logic [STATE_W-1:0] ST_VER_T2       = 5'd5;
    localparam logic [STATE_W-1:0] ST_VER_P        = 5'd6;
    localparam logic [STATE_W-1:0] ST_VER_SLASH    = 5'd7;
    localparam logic [STATE_W-1:0] ST_MAJOR_START  = 5'd8;
    localparam logic [STATE_W-1:0] ST_MAJOR        = 5'd9;
    localparam logic [STATE_W-1:0] ST_MINOR_START  = 5'd10;
    localparam logic [STATE_W-1:0] ST_MINOR        = 5'd11;
    localparam logic [STATE_W-1:0] ST_NL1          = 5'd12;
    localparam logic [STATE_W-1:0] ST_LINE_START   = 5'd13;
    localparam logic [STATE_W-1:0] ST_LWS          = 5'd14;
    localparam logic [STATE_W-1:0] ST_NAME         = 5'd15;
    localparam logic [STATE_W-1:0] ST_SPACE_VALUE  = 5'd16;
    localparam logic [STATE_W-1:0] ST_VALUE        = 5'd17;
    localparam logic [STATE_W-1:0] ST_NL2          = 5'd18;
    localparam logic [STATE_W-1:0] ST_NL3          = 5'd19;

    // Commands
    localparam logic CMD_CONSUME = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    // Status codes
    localparam logic [1:0] STATUS_INDET = 2'd0;
    localparam logic [1:0] STATUS_GOOD  = 2'd1;
    localparam logic [1:0] STATUS_BAD   = 2'd2;

    // Byte kinds
    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_METHOD = 3'd1;
    localparam logic [2:0] KIND_URI    = 3'd2;
    localparam logic [2:0] KIND_NAME   = 3'd3;
    localparam logic [2:0] KIND_VALUE  = 3'd4;

    // Characters of interest
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CTL_MAX  = 8'h1F;
    localparam logic [7:0] ACC_MAX  = 8'hFF;

    typedef struct packed {
        logic is_token;
        logic is_ctl;
        logic is_decimal;
        logic is_lws;
    } byte_class_t;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] byte_kind;
        logic       new_header;
        logic [7:0] out_byte;
        logic [7:0] version_major;
        logic [7:0] version_minor;
    } result_t;

    function automatic logic is_separator(input logic [7:0] b);
        logic sep;
        case (b)
            8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
            8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20, 8'h09:
                sep = 1'b1;
            default:
                sep = 1'b0;
        endcase
        return sep;
    endfunction

    // acc*10 + digit, saturating at 255
    function automatic logic [7:0] acc_digit(input logic [7:0] acc, input logic [7:0] b);
        logic [11:0] v;
        v = {4'd0, acc} * 12'd10 + {8'd0, b[3:0]};
        return (v > {4'd0, ACC_MAX}) ? ACC_MAX : v[7:0];
    endfunction

endpackage

[hdl/hrhp_if.sv]
interface hrhp_req_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] in_byte;

    modport source (output valid, output command, output in_byte, input ready);
    modport sink   (input valid, input command, input in_byte, output ready);
endinterface

interface hrhp_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [2:0] byte_kind;
    logic       new_header;
    logic [7:0] out_byte;
    logic [7:0] version_major;
    logic [7:0] version_minor;

    modport source (output valid, output status, output byte_kind, output new_header,
                    output out_byte, output version_major, output version_minor,
                    input ready);
    modport sink   (input valid, input status, input byte_kind, input new_header,
                    input out_byte, input version_major, input version_minor,
                    output ready);
endinterface

[hdl/hrhp_byte_class.sv]
module hrhp_byte_class (
    input  logic [7:0]                 in_byte,
    output hrhp_pkg::byte_class_t      byte_class
);

    logic is_char;
    logic is_ctl;

    // Bytes above 127 are neither characters nor controls
    assign is_char = (in_byte <= hrhp_pkg::CH_DEL);
    assign is_ctl  = (in_byte <= hrhp_pkg::CTL_MAX) || (in_byte == hrhp_pkg::CH_DEL);

    assign byte_class.is_ctl     = is_ctl;
    assign byte_class.is_token   = is_char && !is_ctl && !hrhp_pkg::is_separator(in_byte);
    assign byte_class.is_decimal = (in_byte >= hrhp_pkg::CH_ZERO) &&
                                   (in_byte <= hrhp_pkg::CH_NINE);
    assign byte_class.is_lws     = (in_byte == hrhp_pkg::CH_SP) || (in_byte == hrhp_pkg::CH_HT);

endmodule

[hdl/hrhp_step.sv]
module hrhp_step (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  logic                    command,
    input  logic [7:0]              in_byte,
    input  hrhp_pkg::byte_class_t   byte_class,
    output hrhp_pkg::result_t       result
);

    logic [hrhp_pkg::STATE_W-1:0] state_reg, state_next;
    logic                         header_seen_reg, header_seen_next;
    logic [7:0]                   major_reg, major_next;
    logic [7:0]                   minor_reg, minor_next;
    logic [1:0]                   status;
    logic [2:0]                   kind;
    logic                         new_hdr;

    always_comb
    begin
        state_next       = state_reg;
        header_seen_next = header_seen_reg;
        major_next       = major_reg;
        minor_next       = minor_reg;
        status           = hrhp_pkg::STATUS_INDET;
        kind             = hrhp_pkg::KIND_NONE;
        new_hdr          = 1'b0;

        if (command == hrhp_pkg::CMD_RESTART)
        begin
            state_next       = hrhp_pkg::ST_METHOD_START;
            header_seen_next = 1'b0;
            major_next       = 8'd0;
            minor_next       = 8'd0;
        end
        else
        begin
            unique case (state_reg)
                hrhp_pkg::ST_METHOD_START:
                begin
                    if (!byte_class.is_token)
                        status = hrhp_pkg::STATUS_BAD;
                    else
                    begin
                        state_next = hrhp_pkg::ST_METHOD;
                        kind       = hrhp_pkg::KIND_METHOD;
                    end
                end
                hrhp_pkg::ST_METHOD:
                begin
                    if (in_byte == hrhp_pkg::CH_SP)
                        state_next = hrhp_pkg::ST_URI;
                    else if (!byte_class.is_token)
                        status = hrhp_pkg::STATUS_BAD;
                    else
                        kind = hrhp_pkg::KIND_METHOD;
                end
                hrhp_pkg::ST_URI:
                begin
                    if (in_byte == hrhp_pkg::CH_SP)
                        state_next = hrhp_pkg::ST_VER_H;
                    else if (byte_class.is_ctl)
                        status = hrhp_pkg::STATUS_BAD;
                    else
                        kind = hrhp_pkg::KIND_URI;
                end
                hrhp_pkg::ST_VER_H:
                begin
                    if (in_byte == hrhp_pkg::CH_H)
                        state_next = hrhp_pkg::ST_VER_T1;
                    else
                        status = hrhp_pkg::STATUS_BAD;
                end
                hrhp_pkg::ST_VER_T1:
                begin
                    if (in_byte == hrhp_pkg::CH_T)
                        state_next = hrhp_pkg::ST_VER_T2;
                    else
                        status = hrhp_pkg::STATUS_BAD;
                end
                hrhp_pkg::ST_VER_T2:
                begin
                    if (in_byte == hrhp_pkg::CH_T)
                        state_next = hrhp_pkg::ST_VER_P;
                    else
                        status = hrhp_pkg::STATUS_BAD;
                end
                hrhp_pkg::ST_VER_P:
                begin
                    if (in_byte == hrhp_pkg::CH_P)
                        state_next = hrhp_pkg::ST_VER_SLASH;
                    else
                        status = hrhp_pkg::STATUS_BAD;
                end
                hrhp_pkg::ST_VER_SLASH:
                begin
                    if (in_byte == hrhp_pkg::CH_SLASH)
                    begin
                        major_next = 8'd0;
                        minor_next = 8'd0;
                        state_next = hrhp_pkg::ST_MAJOR_START;
                    end
                    else
                        status = hrhp_pkg::STATUS_BAD;
                end
                hrhp_pkg::ST_MAJOR_START:
                begin
                    if (byte_class.is_decimal)
                    begin
                        major_next = hrhp_pkg::acc_digit(major_reg, in_byte);
                        state_next = hrhp_pkg::ST_MAJOR;
                    end
                    else
                        status = hrhp_pkg::STATUS_BAD;
                end
                hrhp_pkg::ST_MAJOR:
                begin
                    if (in_byte == hrhp_pkg::CH_DOT)
                        state_next = hrhp_pkg::ST_MINOR_START;
                    else if (byte_class.is_decimal)
                        major_next = hrhp_pkg::acc_digit(major_reg, in_byte);
                    else
                        status = hrhp_pkg::STATUS_BAD;
                end
                hrhp_pkg::ST_MINOR_START:
                begin
                    if (byte_class.is_decimal)
                    begin
                        minor_next = hrhp_pkg::acc_digit(minor_reg, in_byte);
                        state_next = hrhp_pkg::ST_MINOR;
                    end
                    else
                        status = hrhp_pkg::STATUS_BAD;
                end
                hrhp_pkg::ST_MINOR:
                begin
                    if (in_byte == hrhp_pkg::CH_CR)
                        state_next = hrhp_pkg::ST_NL1;
                    else if (byte_class.is_decimal)
                        minor_next = hrhp_pkg::acc_digit(minor_reg, in_byte);
                    else
                        status = hrhp_pkg::STATUS_BAD;
                end
                hrhp_pkg::ST_NL1:
                begin
                    if (in_byte == hrhp_pkg::CH_LF)
                        state_next = hrhp_pkg::ST_LINE_START;
                    else
                        status = hrhp_pkg::STATUS_BAD;
                end
                hrhp_pkg::ST_LINE_START:
                begin
                    if (in_byte == hrhp_pkg::CH_CR)
                        state_next = hrhp_pkg::ST_NL3;
                    else if (header_seen_reg && byte_class.is_lws)
                        state_next = hrhp_pkg::ST_LWS;
                    else if (!byte_class.is_token)
                        status = hrhp_pkg::STATUS_BAD;
                    else
                    begin
                        header_seen_next = 1'b1;
                        kind             = hrhp_pkg::KIND_NAME;
                        new_hdr          = 1'b1;
                        state_next       = hrhp_pkg::ST_NAME;
                    end
                end
                hrhp_pkg::ST_LWS:
                begin
                    if (in_byte == hrhp_pkg::CH_CR)
                        state_next = hrhp_pkg::ST_NL2;
                    else if (byte_class.is_lws)
                        state_next = hrhp_pkg::ST_LWS;
                    else if (byte_class.is_ctl)
                        status = hrhp_pkg::STATUS_BAD;
                    else
                    begin
                        state_next = hrhp_pkg::ST_VALUE;
                        kind       = hrhp_pkg::KIND_VALUE;
                    end
                end
                hrhp_pkg::ST_NAME:
                begin
                    if (in_byte == hrhp_pkg::CH_COLON)
                        state_next = hrhp_pkg::ST_SPACE_VALUE;
                    else if (!byte_class.is_token)
                        status = hrhp_pkg::STATUS_BAD;
                    else
                        kind = hrhp_pkg::KIND_NAME;
                end
                hrhp_pkg::ST_SPACE_VALUE:
                begin
                    if (in_byte == hrhp_pkg::CH_SP)
                        state_next = hrhp_pkg::ST_VALUE;
                    else
                        status = hrhp_pkg::STATUS_BAD;
                end
                hrhp_pkg::ST_VALUE:
                begin
                    if (in_byte == hrhp_pkg::CH_CR)
                        state_next = hrhp_pkg::ST_NL2;
                    else if (byte_class.is_ctl)
                        status = hrhp_pkg::STATUS_BAD;
                    else
                        kind = hrhp_pkg::KIND_VALUE;
                end
                hrhp_pkg::ST_NL2:
                begin
                    if (in_byte == hrhp_pkg::CH_LF)
                        state_next = hrhp_pkg::ST_LINE_START;
                    else
                        status = hrhp_pkg::STATUS_BAD;
                end
                hrhp_pkg::ST_NL3:
                begin
                    status = (in_byte == hrhp_pkg::CH_LF) ? hrhp_pkg::STATUS_GOOD
                                                          : hrhp_pkg::STATUS_BAD;
                end
                default:
                begin
                    status = hrhp_pkg::STATUS_BAD;
                end
            endcase
        end
    end

    assign result.status        = status;
    assign result.byte_kind     = kind;
    assign result.new_header    = new_hdr;
    assign result.out_byte      = (kind != hrhp_pkg::KIND_NONE) ? in_byte : 8'd0;
    assign result.version_major = major_next;
    assign result.version_minor = minor_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= hrhp_pkg::ST_METHOD_START;
            header_seen_reg <= 1'b0;
            major_reg       <= 8'd0;
            minor_reg       <= 8'd0;
        end
        else if (advance)
        begin
            state_reg       <= state_next;
            header_seen_reg <= header_seen_next;
            major_reg       <= major_next;
            minor_reg       <= minor_next;
        end
    end

endmodule

[hdl/http_request_header_parser.sv]
// HTTP/1.1 request-line and header parser. Feed one request byte per beat on
// req (command 0), or a restart beat (command 1) to begin a new request; every
// input beat yields exactly one result beat on rsp, in order. A result gives
// the running status (indeterminate, good once the blank line after the
// headers ends, bad on a malformed byte; bad and good leave the parser where
// it was), tags the byte as method, URI, header-name or header-value text,
// flags the first byte of each header name, echoes tagged bytes and reports
// the HTTP major/minor version seen so far (decimal, saturating at 255).
// Throughput is one byte per clock cycle while rsp.ready does not stall the
// result: the whole state step is a single level of logic between the input
// register and the result register, and the next byte sees the updated state
// on the following cycle. A result passes from the input register through the
// result register to rsp. Both sides are registered; req.ready depends only
// on rsp.ready and local state. While a finished result waits to be taken,
// the block takes one more byte into its input register and then holds
// req.ready low until the result moves on.
module http_request_header_parser (
    input  logic        clk,
    input  logic        rst_n,
    hrhp_req_if.sink    req,
    hrhp_rsp_if.source  rsp
);

    // Input stage
    logic              in_valid_reg;
    logic              command_reg;
    logic [7:0]        byte_reg;

    // Result stage
    logic              out_valid_reg;
    hrhp_pkg::result_t result_reg;

    hrhp_pkg::byte_class_t byte_class;
    hrhp_pkg::result_t     step_result;
    logic                  advance;

    // Advance the held byte through the parser when the result slot is free
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (req.ready)
            in_valid_reg <= req.valid;
    end

    // Payload holds until the next accepted beat
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            command_reg <= req.command;
            byte_reg    <= req.in_byte;
        end
    end

    hrhp_byte_class u_byte_class (
        .in_byte    (byte_reg),
        .byte_class (byte_class)
    );

    hrhp_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .command    (command_reg),
        .in_byte    (byte_reg),
        .byte_class (byte_class),
        .result     (step_result)
    );

    // Result register: drop the valid once taken, load on advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= step_result;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = result_reg.status;
    assign rsp.byte_kind     = result_reg.byte_kind;
    assign rsp.new_header    = result_reg.new_header;
    assign rsp.out_byte      = result_reg.out_byte;
    assign rsp.version_major = result_reg.version_major;
    assign rsp.version_minor = result_reg.version_minor;

endmodule

[hdl/hrhp_checker.sv]
module hrhp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [1:0] status,
    input logic [2:0] byte_kind,
    input logic       new_header,
    input logic [7:0] out_byte
);

    // A stalled result beat holds its contents
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(byte_kind)
            && $stable(new_header) && $stable(out_byte))
        else $error("result beat changed while stalled");

    // Untagged bytes are not echoed
    a_untagged_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && byte_kind == hrhp_pkg::KIND_NONE |-> out_byte == 8'd0)
        else $error("untagged byte echoed");

    // A new header always starts on a header-name byte
    a_new_header_name: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && new_header |-> byte_kind == hrhp_pkg::KIND_NAME)
        else $error("new header flag on a non-name byte");

    // Good or bad verdicts never tag the byte
    a_verdict_untagged: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != hrhp_pkg::STATUS_INDET |->
            byte_kind == hrhp_pkg::KIND_NONE && !new_header)
        else $error("tagged byte on a final status");

endmodule

bind http_request_header_parser hrhp_checker u_hrhp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .status     (rsp.status),
    .byte_kind  (rsp.byte_kind),
    .new_header (rsp.new_header),
    .out_byte   (rsp.out_byte)
);

[tb/sv/http_request_header_parser_tb.sv]
module http_request_header_parser_tb;

    // Watchdog limit: cycles in a row with no beat moving on either side.
    // The receiver hold-off below and the idle gaps of a 60% sender both stay
    // far below it, so this leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 80;
    localparam int PHASE_BEATS    = 130;
    localparam int DRAIN_CYCLES   = 12;

    // Characters that may appear in a method or header-name token.
    localparam string TOKEN_CHARS =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789!#$%&'*+-.^_`|~";

    // Tracks the parser as the block should see it and holds the result
    // beats still owed by the block, oldest first.
    class parse_result_board;
        hrhp_pkg::result_t pending_results[$];
        int unsigned       errors;
        logic [4:0]        pstate;
        logic              header_seen;
        logic [7:0]        major_acc;
        logic [7:0]        minor_acc;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            pstate      = hrhp_pkg::ST_METHOD_START;
            header_seen = 1'b0;
            major_acc   = 8'd0;
            minor_acc   = 8'd0;
        endfunction

        function bit is_ctl(input logic [7:0] b);
            return (b <= 8'd31) || (b == 8'd127);
        endfunction

        function bit is_delim(input logic [7:0] b);
            case (b)
                "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
                "/", "[", "]", "?", "=", "{", "}", " ", "\t":
                    return 1'b1;
                default:
                    return 1'b0;
            endcase
        endfunction

        // High bytes act as negative chars: not CHAR, so never a token.
        function bit is_token(input logic [7:0] b);
            return (b <= 8'd127) && !is_ctl(b) && !is_delim(b);
        endfunction

        function bit is_numeral(input logic [7:0] b);
            return (b >= hrhp_pkg::CH_ZERO) && (b <= hrhp_pkg::CH_NINE);
        endfunction

        function logic [7:0] dec_push(input logic [7:0] acc, input logic [7:0] b);
            int unsigned v;
            v = acc * 10 + (b - hrhp_pkg::CH_ZERO);
            return (v > 255) ? 8'd255 : v[7:0];
        endfunction

        // Step the parser by one accepted input beat and queue its result.
        function void note_byte(input logic cmd, input logic [7:0] b);
            hrhp_pkg::result_t r;
            r.status     = hrhp_pkg::STATUS_INDET;
            r.byte_kind  = hrhp_pkg::KIND_NONE;
            r.new_header = 1'b0;
            if (cmd == hrhp_pkg::CMD_RESTART)
            begin
                restart();
            end
            else
            begin
                case (pstate)
                    hrhp_pkg::ST_METHOD_START:
                        if (!is_token(b))
                            r.status = hrhp_pkg::STATUS_BAD;
                        else
                        begin
                            pstate      = hrhp_pkg::ST_METHOD;
                            r.byte_kind = hrhp_pkg::KIND_METHOD;
                        end
                    hrhp_pkg::ST_METHOD:
                        if (b == hrhp_pkg::CH_SP)
                            pstate = hrhp_pkg::ST_URI;
                        else if (!is_token(b))
                            r.status = hrhp_pkg::STATUS_BAD;
                        else
                            r.byte_kind = hrhp_pkg::KIND_METHOD;
                    hrhp_pkg::ST_URI:
                        if (b == hrhp_pkg::CH_SP)
                            pstate = hrhp_pkg::ST_VER_H;
                        else if (is_ctl(b))
                            r.status = hrhp_pkg::STATUS_BAD;
                        else
                            r.byte_kind = hrhp_pkg::KIND_URI;
                    hrhp_pkg::ST_VER_H:
                        if (b == hrhp_pkg::CH_H)
                            pstate = hrhp_pkg::ST_VER_T1;
                        else
                            r.status = hrhp_pkg::STATUS_BAD;
                    hrhp_pkg::ST_VER_T1:
                        if (b == hrhp_pkg::CH_T)
                            pstate = hrhp_pkg::ST_VER_T2;
                        else
                            r.status = hrhp_pkg::STATUS_BAD;
                    hrhp_pkg::ST_VER_T2:
                        if (b == hrhp_pkg::CH_T)
                            pstate = hrhp_pkg::ST_VER_P;
                        else
                            r.status = hrhp_pkg::STATUS_BAD;
                    hrhp_pkg::ST_VER_P:
                        if (b == hrhp_pkg::CH_P)
                            pstate = hrhp_pkg::ST_VER_SLASH;
                        else
                            r.status = hrhp_pkg::STATUS_BAD;
                    hrhp_pkg::ST_VER_SLASH:
                        if (b == hrhp_pkg::CH_SLASH)
                        begin
                            major_acc = 8'd0;
                            minor_acc = 8'd0;
                            pstate    = hrhp_pkg::ST_MAJOR_START;
                        end
                        else
                            r.status = hrhp_pkg::STATUS_BAD;
                    hrhp_pkg::ST_MAJOR_START:
                        if (is_numeral(b))
                        begin
                            major_acc = dec_push(major_acc, b);
                            pstate    = hrhp_pkg::ST_MAJOR;
                        end
                        else
                            r.status = hrhp_pkg::STATUS_BAD;
                    hrhp_pkg::ST_MAJOR:
                        if (b == hrhp_pkg::CH_DOT)
                            pstate = hrhp_pkg::ST_MINOR_START;
                        else if (is_numeral(b))
                            major_acc = dec_push(major_acc, b);
                        else
                            r.status = hrhp_pkg::STATUS_BAD;
                    hrhp_pkg::ST_MINOR_START:
                        if (is_numeral(b))
                        begin
                            minor_acc = dec_push(minor_acc, b);
                            pstate    = hrhp_pkg::ST_MINOR;
                        end
                        else
                            r.status = hrhp_pkg::STATUS_BAD;
                    hrhp_pkg::ST_MINOR:
                        if (b == hrhp_pkg::CH_CR)
                            pstate = hrhp_pkg::ST_NL1;
                        else if (is_numeral(b))
                            minor_acc = dec_push(minor_acc, b);
                        else
                            r.status = hrhp_pkg::STATUS_BAD;
                    hrhp_pkg::ST_NL1:
                        if (b == hrhp_pkg::CH_LF)
                            pstate = hrhp_pkg::ST_LINE_START;
                        else
                            r.status = hrhp_pkg::STATUS_BAD;
                    hrhp_pkg::ST_LINE_START:
                        if (b == hrhp_pkg::CH_CR)
                            pstate = hrhp_pkg::ST_NL3;
                        else if (header_seen && (b == hrhp_pkg::CH_SP || b == hrhp_pkg::CH_HT))
                            pstate = hrhp_pkg::ST_LWS;
                        else if (!is_token(b))
                            r.status = hrhp_pkg::STATUS_BAD;
                        else
                        begin
                            header_seen  = 1'b1;
                            r.byte_kind  = hrhp_pkg::KIND_NAME;
                            r.new_header = 1'b1;
                            pstate       = hrhp_pkg::ST_NAME;
                        end
                    hrhp_pkg::ST_LWS:
                        if (b == hrhp_pkg::CH_CR)
                            pstate = hrhp_pkg::ST_NL2;
                        else if (b == hrhp_pkg::CH_SP || b == hrhp_pkg::CH_HT)
                            pstate = hrhp_pkg::ST_LWS;
                        else if (is_ctl(b))
                            r.status = hrhp_pkg::STATUS_BAD;
                        else
                        begin
                            pstate      = hrhp_pkg::ST_VALUE;
                            r.byte_kind = hrhp_pkg::KIND_VALUE;
                        end
                    hrhp_pkg::ST_NAME:
                        if (b == hrhp_pkg::CH_COLON)
                            pstate = hrhp_pkg::ST_SPACE_VALUE;
                        else if (!is_token(b))
                            r.status = hrhp_pkg::STATUS_BAD;
                        else
                            r.byte_kind = hrhp_pkg::KIND_NAME;
                    hrhp_pkg::ST_SPACE_VALUE:
                        if (b == hrhp_pkg::CH_SP)
                            pstate = hrhp_pkg::ST_VALUE;
                        else
                            r.status = hrhp_pkg::STATUS_BAD;
                    hrhp_pkg::ST_VALUE:
                        if (b == hrhp_pkg::CH_CR)
                            pstate = hrhp_pkg::ST_NL2;
                        else if (is_ctl(b))
                            r.status = hrhp_pkg::STATUS_BAD;
                        else
                            r.byte_kind = hrhp_pkg::KIND_VALUE;
                    hrhp_pkg::ST_NL2:
                        if (b == hrhp_pkg::CH_LF)
                            pstate = hrhp_pkg::ST_LINE_START;
                        else
                            r.status = hrhp_pkg::STATUS_BAD;
                    hrhp_pkg::ST_NL3:
                        r.status = (b == hrhp_pkg::CH_LF) ? hrhp_pkg::STATUS_GOOD
                                                          : hrhp_pkg::STATUS_BAD;
                    default:
                        r.status = hrhp_pkg::STATUS_BAD;
                endcase
            end
            r.out_byte      = (r.byte_kind != hrhp_pkg::KIND_NONE) ? b : 8'd0;
            r.version_major = major_acc;
            r.version_minor = minor_acc;
            pending_results.insert(pending_results.size(), r);
        endfunction

        function void compare_field(input string name, input logic [7:0] want,
                                    input logic [7:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        // Match one accepted result beat against the oldest owed result.
        function void check_result(input hrhp_pkg::result_t got);
            hrhp_pkg::result_t want;
            if (pending_results.size() == 0)
            begin
                $error("result beat with no input byte owing one (status %0d, kind %0d)",
                       got.status, got.byte_kind);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("status", 8'(want.status), 8'(got.status));
                compare_field("byte_kind", 8'(want.byte_kind), 8'(got.byte_kind));
                compare_field("new_header", 8'(want.new_header), 8'(got.new_header));
                compare_field("out_byte", want.out_byte, got.out_byte);
                compare_field("version_major", want.version_major, got.version_major);
                compare_field("version_minor", want.version_minor, got.version_minor);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    hrhp_req_if req();
    hrhp_rsp_if rsp();

    http_request_header_parser dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    parse_result_board results = new();

    int sender_idle_pct = 0;
    int rx_stall_pct    = 0;
    bit hold_rx_req     = 1'b0;
    int beats_sent      = 0;
    int quiet_cycles    = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Monitor and watchdog. Sample both handshakes at the rising edge, before
    // any nonblocking update of this step lands, so the order of processes
    // within the step does not matter.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req.valid && req.ready)
                results.note_byte(req.command, req.in_byte);
            if (rsp.valid && rsp.ready)
                results.check_result(hrhp_pkg::result_t'{rsp.status, rsp.byte_kind,
                                                         rsp.new_header, rsp.out_byte,
                                                         rsp.version_major,
                                                         rsp.version_minor});
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
                $display("http_request_header_parser verification failed");
                $finish;
            end
        end
    end

    // Receiver. Stall at the rate of the current phase; on request, hold off
    // for a long stretch so the block backs up and drops req.ready while the
    // sender keeps offering bytes.
    initial
    begin
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_rx_req)
            begin
                hold_rx_req = 1'b0;
                rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
                rsp.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Offer one beat, idling first at the sender rate, and hold it until the
    // block takes it. Return at the accepting edge, so a following beat goes
    // out with no gap unless the idle draw says otherwise.
    task automatic send_beat(input logic cmd, input logic [7:0] b);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid   <= 1'b1;
        req.command <= cmd;
        req.in_byte <= b;
        do
            @(posedge clk);
        while (!req.ready);
        beats_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_beat(hrhp_pkg::CMD_CONSUME, s[i]);
    endtask

    function automatic logic [7:0] rand_token_char();
        return TOKEN_CHARS[$urandom_range(TOKEN_CHARS.len() - 1)];
    endfunction

    // Printable most of the time, any byte now and then (high bytes too).
    function automatic logic [7:0] rand_text_byte();
        if ($urandom_range(3) == 0)
            return 8'($urandom_range(255));
        return 8'($urandom_range(126, 32));
    endfunction

    function automatic logic [7:0] rand_value_char();
        logic [7:0] c;
        do
            c = rand_text_byte();
        while (c <= hrhp_pkg::CTL_MAX || c == hrhp_pkg::CH_DEL);
        return c;
    endfunction

    function automatic logic [7:0] rand_uri_char();
        logic [7:0] c;
        do
            c = rand_value_char();
        while (c == hrhp_pkg::CH_SP);
        return c;
    endfunction

    function automatic logic [7:0] rand_digit();
        return hrhp_pkg::CH_ZERO + 8'($urandom_range(9));
    endfunction

    // Build a well-formed request with random content, then maybe corrupt a
    // byte or cut it short, and send it, usually behind a restart beat.
    task automatic send_request();
        logic [7:0] bytes_q[$];
        string      tag;
        int         keep;
        tag = "HTTP/";
        repeat ($urandom_range(8, 1)) bytes_q.insert(bytes_q.size(), rand_token_char());
        bytes_q.insert(bytes_q.size(), hrhp_pkg::CH_SP);
        repeat ($urandom_range(10)) bytes_q.insert(bytes_q.size(), rand_uri_char());
        bytes_q.insert(bytes_q.size(), hrhp_pkg::CH_SP);
        for (int i = 0; i < tag.len(); i++)
            bytes_q.insert(bytes_q.size(), tag[i]);
        repeat ($urandom_range(4, 1)) bytes_q.insert(bytes_q.size(), rand_digit());
        bytes_q.insert(bytes_q.size(), hrhp_pkg::CH_DOT);
        repeat ($urandom_range(4, 1)) bytes_q.insert(bytes_q.size(), rand_digit());
        bytes_q.insert(bytes_q.size(), hrhp_pkg::CH_CR);
        bytes_q.insert(bytes_q.size(), hrhp_pkg::CH_LF);
        repeat ($urandom_range(3))
        begin
            repeat ($urandom_range(6, 1)) bytes_q.insert(bytes_q.size(), rand_token_char());
            bytes_q.insert(bytes_q.size(), hrhp_pkg::CH_COLON);
            bytes_q.insert(bytes_q.size(), hrhp_pkg::CH_SP);
            repeat ($urandom_range(8)) bytes_q.insert(bytes_q.size(), rand_value_char());
            bytes_q.insert(bytes_q.size(), hrhp_pkg::CH_CR);
            bytes_q.insert(bytes_q.size(), hrhp_pkg::CH_LF);
            // folded continuation line
            if ($urandom_range(2) == 0)
            begin
                repeat ($urandom_range(3, 1))
                    bytes_q.insert(bytes_q.size(),
                                   $urandom_range(1) ? hrhp_pkg::CH_SP : hrhp_pkg::CH_HT);
                repeat ($urandom_range(5)) bytes_q.insert(bytes_q.size(), rand_value_char());
                bytes_q.insert(bytes_q.size(), hrhp_pkg::CH_CR);
                bytes_q.insert(bytes_q.size(), hrhp_pkg::CH_LF);
            end
        end
        bytes_q.insert(bytes_q.size(), hrhp_pkg::CH_CR);
        bytes_q.insert(bytes_q.size(), hrhp_pkg::CH_LF);

        if ($urandom_range(99) < 20)
            bytes_q[$urandom_range(bytes_q.size() - 1)] = 8'($urandom_range(255));
        if ($urandom_range(99) < 10)
        begin
            keep = $urandom_range(bytes_q.size() - 1, 1);
            while (bytes_q.size() > keep)
                void'(bytes_q.pop_back());
        end

        if ($urandom_range(9) != 0)
            send_beat(hrhp_pkg::CMD_RESTART, 8'($urandom_range(255)));
        foreach (bytes_q[i])
            send_beat(hrhp_pkg::CMD_CONSUME, bytes_q[i]);
        // trailing bytes after the end land on a finished, stuck or unfinished parser
        if ($urandom_range(4) == 0)
            repeat ($urandom_range(2, 1))
                send_beat(hrhp_pkg::CMD_CONSUME, 8'($urandom_range(255)));
    endtask

    task automatic send_noise();
        repeat ($urandom_range(6, 1))
            send_beat(($urandom_range(7) == 0) ? hrhp_pkg::CMD_RESTART : hrhp_pkg::CMD_CONSUME,
                      8'($urandom_range(255)));
    endtask

    initial
    begin
        int  phase_start;
        bit  hold_done;
        hold_done   = 1'b0;
        rst_n       = 1'b0;
        req.valid   <= 1'b0;
        req.command <= hrhp_pkg::CMD_CONSUME;
        req.in_byte <= 8'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: restart ignores its byte; a control and a high byte are
        // bad at method start; a high byte is bad inside the method but a
        // plain URI character; 999 saturates the major version; a folded
        // line before any header is bad; the blank line completes, and a
        // further byte after completion is judged from the same state.
        send_beat(hrhp_pkg::CMD_RESTART, 8'hFF);
        send_beat(hrhp_pkg::CMD_CONSUME, 8'h00);
        send_beat(hrhp_pkg::CMD_CONSUME, 8'hFF);
        send_text("G");
        send_beat(hrhp_pkg::CMD_CONSUME, 8'h80);
        send_text(" ");
        send_beat(hrhp_pkg::CMD_CONSUME, 8'hFF);
        send_text(" HTTP/999.1\r\n \r\n\n");
        send_beat(hrhp_pkg::CMD_RESTART, 8'h00);

        // Random traffic, one idling profile per phase.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin sender_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin sender_idle_pct = 60; rx_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  rx_stall_pct = 60; end
                default: begin sender_idle_pct = 16; rx_stall_pct = 16; end
            endcase
            phase_start = beats_sent;
            while (beats_sent - phase_start < PHASE_BEATS)
            begin
                if (ph == 0 && !hold_done && beats_sent - phase_start >= 40)
                begin
                    hold_rx_req = 1'b1;
                    hold_done   = 1'b1;
                end
                if ($urandom_range(99) < 80)
                    send_request();
                else
                    send_noise();
            end
        end
        req.valid <= 1'b0;

        // Drain: wait for every owed result, then watch a little longer for
        // any stray beat.
        while (results.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (results.pending_results.size() != 0)
        begin
            $error("%0d results never arrived", results.pending_results.size());
            results.errors++;
        end

        if (results.errors == 0)
            $display("http_request_header_parser verification clean");
        else
            $display("http_request_header_parser verification failed");
        $finish;
    end

endmodule
